// ----- design/rle_bitpacked_hybrid_decoder_assert.svh -----
// assertion macros shared by the rle / bit-packed hybrid decoder
`ifndef RLE_BITPACKED_HYBRID_DECODER_ASSERT_SVH
`define RLE_BITPACKED_HYBRID_DECODER_ASSERT_SVH

// same-cycle implication, held off during reset
`define RBHD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define RBHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rbhd_pkg.sv -----
// shared types and constants of the rle / bit-packed hybrid decoder
package rbhd_pkg;

    localparam int VW_W        = 6;
    localparam int TOTAL_W     = 31;
    localparam int INDEX_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_BURST   = 8;
    localparam int BURST_W     = $clog2(MAX_BURST + 1);

    // register indexes on the configuration channel
    localparam logic CFG_VALUE_WIDTH  = 1'b0;
    localparam logic CFG_TOTAL_VALUES = 1'b1;

    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_ERROR    = 2'd2
    } t_status;

    // one classified input byte
    typedef struct packed {
        logic [7:0] data;
        logic [6:0] low7;
        logic       cont;
        logic       eop;
    } t_cmd;

    // one result item
    typedef struct packed {
        t_status              status;
        logic                 last;
        logic [TOTAL_W-1:0]   rep;
        logic [INDEX_W-1:0]   index;
    } t_result;

endpackage

// ----- design/rle_bitpacked_hybrid_decoder.sv -----
// top level of the rle / bit-packed hybrid index decoder
//
// Page bytes enter on the slave stream, one byte per transfer in tdata, with
// tlast on the final byte of the page. The first four bytes are a length
// prefix and are skipped. Decoded values leave on the master stream: tdata
// holds the index and its repeat count, tlast marks the last result of a byte
// and tuser carries the page status on the last result of the final byte.
// The config channel sets the value width (index 0) and the values expected
// per page (index 1); write it only while no byte is in flight.
// A byte waits in a two-entry queue, then the engine takes it; a byte of a
// bit-packed run then yields up to eight values in the unpack loop. The first
// result of a byte passes through the queue and the output register, an
// unpacked value through the bit buffer as well. The engine's unpack loop,
// one value a cycle, sets the rate on packed runs; other bytes go at one per
// cycle; both hold while the receiver stalls.
// Reset clears all decode state and sets width and count to one.
// When the receiver stalls, the output register holds its result, the engine
// waits, and once the queue holds two bytes the slave port drops tready.
module rle_bitpacked_hybrid_decoder
    import rbhd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,    // [7:0] in_byte
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [63:0]           o_m_tdata,    // [31:0] index_value, [62:32] repeat_res, zero pad
    output logic                  o_m_tlast,
    output logic [1:0]            o_m_tuser,    // [1:0] status
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "rle_bitpacked_hybrid_decoder_assert.svh"

    logic [VW_W-1:0]    r_value_width;
    logic [TOTAL_W-1:0] r_total_values;
    t_cmd               w_cmd;
    logic               w_cmd_valid;
    logic               w_cmd_pop;
    t_result            w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_width  <= VW_W'(1);
            r_total_values <= TOTAL_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VALUE_WIDTH:  r_value_width  <= i_cfg_data[VW_W-1:0];
                CFG_TOTAL_VALUES: r_total_values <= i_cfg_data[TOTAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rbhd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_byte      (i_s_tdata),
        .i_eop       (i_s_tlast),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    rbhd_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value_width  (r_value_width),
        .i_total_values (r_total_values),
        .i_cmd          (w_cmd),
        .i_cmd_valid    (w_cmd_valid),
        .o_cmd_pop      (w_cmd_pop),
        .o_res          (w_res),
        .o_res_valid    (o_m_tvalid),
        .i_res_ready    (i_m_tready)
    );

    assign o_m_tdata = {1'b0, w_res.rep, w_res.index};
    assign o_m_tlast = w_res.last;
    assign o_m_tuser = w_res.status;

    `RBHD_ASSERT_IMPL(a_status_on_last, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser != ST_BUSY), o_m_tlast,
        "status on a result that is not the last of its byte")
    `RBHD_ASSERT_IMPL(a_zero_rep_is_status, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tdata[62:32] == '0),
        o_m_tlast && (o_m_tuser != ST_BUSY) && (o_m_tdata[31:0] == '0),
        "zero repeat count outside a status-only result")
    `RBHD_ASSERT_NEXT(a_queue_fill, i_clk, i_rst_n,
        i_s_tvalid && o_s_tready && !w_cmd_valid, w_cmd_valid,
        "byte pushed into an empty queue was lost")

endmodule

// ----- design/rbhd_front.sv -----
// input side: accepts page bytes, classifies them and queues them for the engine
module rbhd_front
    import rbhd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_eop,
    output t_cmd       o_cmd,
    output logic       o_cmd_valid,
    input  logic       i_cmd_pop
);

    t_cmd               r_q [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;
    logic               pop;
    t_cmd               cmd_in;

    assign o_ready     = (r_count != Q_CNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign push        = i_valid && o_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        cmd_in.data = i_byte;
        cmd_in.low7 = i_byte[6:0];
        cmd_in.cont = i_byte[7];
        cmd_in.eop  = i_eop;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/rbhd_engine.sv -----
// decode engine: prefix skip, varint headers, repeated runs and bit unpacking
module rbhd_engine
    import rbhd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [VW_W-1:0]    i_value_width,
    input  logic [TOTAL_W-1:0] i_total_values,
    input  t_cmd               i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    output t_result            o_res,
    output logic               o_res_valid,
    input  logic               i_res_ready
);

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_HEADER,
        PH_PACKED,
        PH_RLEVAL,
        PH_DONE,
        PH_FAIL
    } t_phase;

    typedef enum logic {
        ES_IDLE,
        ES_UNPACK
    } t_est;

    t_est               r_est,       n_est;
    t_phase             r_phase,     n_phase;
    logic [1:0]         r_pfx_cnt,   n_pfx_cnt;
    logic [31:0]        r_hdr_acc,   n_hdr_acc;
    logic [2:0]         r_hdr_shift, n_hdr_shift;
    logic [31:0]        r_run_rem,   n_run_rem;
    logic [31:0]        r_val_acc,   n_val_acc;
    logic [2:0]         r_val_cnt,   n_val_cnt;
    logic [39:0]        r_bit_buf,   n_bit_buf;
    logic [5:0]         r_bit_cnt,   n_bit_cnt;
    logic [TOTAL_W-1:0] r_dec_cnt,   n_dec_cnt;
    logic [BURST_W-1:0] r_burst,     n_burst;
    logic               r_eop_hold,  n_eop_hold;
    logic               r_out_valid, n_out_valid;
    t_result            r_out;

    logic               wok;
    logic [32:0]        mask_ext;
    logic [31:0]        mask;
    logic               slot_free;
    logic [2:0]         hs_sat;
    logic [31:0]        hdr_part;
    logic [31:0]        hdr_new;
    logic [TOTAL_W-1:0] rem;
    logic [33:0]        pk_vals;
    logic [31:0]        pk_run;
    logic [31:0]        val_new;
    logic [2:0]         vbc_new;
    logic [2:0]         nb;
    logic [TOTAL_W-1:0] rle_cnt;
    logic [5:0]         bc_after;
    logic               cond;
    logic               nxt;
    logic               do_emit;
    logic               do_end;
    logic               go_unpack;
    logic               emit;
    t_result            res;

    assign wok       = (i_value_width != '0) && (i_value_width <= VW_W'(32));
    assign mask_ext  = (33'd1 << i_value_width) - 33'd1;
    assign mask      = mask_ext[31:0];
    assign slot_free = !r_out_valid || i_res_ready;

    // varint header: seven bits a byte, fifth byte closes the header
    assign hs_sat = (r_hdr_shift > 3'd4) ? 3'd4 : r_hdr_shift;
    always_comb begin
        case (hs_sat)
            3'd0:    hdr_part = {25'd0, i_cmd.low7};
            3'd1:    hdr_part = {18'd0, i_cmd.low7, 7'd0};
            3'd2:    hdr_part = {11'd0, i_cmd.low7, 14'd0};
            3'd3:    hdr_part = {4'd0, i_cmd.low7, 21'd0};
            default: hdr_part = {i_cmd.low7[3:0], 28'd0};
        endcase
    end
    assign hdr_new = r_hdr_acc | hdr_part;

    assign rem     = i_total_values - r_dec_cnt;
    assign pk_vals = {1'b0, hdr_new[31:1], 2'b00} << 1;
    assign pk_run  = (pk_vals < {3'd0, rem}) ? pk_vals[31:0] : {1'b0, rem};

    // repeated value: little-endian bytes, ceil(width/8) of them
    always_comb begin
        case (r_val_cnt)
            3'd0:    val_new = r_val_acc | {24'd0, i_cmd.data};
            3'd1:    val_new = r_val_acc | {16'd0, i_cmd.data, 8'd0};
            3'd2:    val_new = r_val_acc | {8'd0, i_cmd.data, 16'd0};
            3'd3:    val_new = r_val_acc | {i_cmd.data, 24'd0};
            default: val_new = r_val_acc;
        endcase
    end
    assign vbc_new = r_val_cnt + 3'd1;
    assign nb      = i_value_width[5:3] + {2'd0, |i_value_width[2:0]};
    assign rle_cnt = (r_run_rem < {1'b0, rem}) ? r_run_rem[TOTAL_W-1:0] : rem;

    // unpack step conditions, now and after this value
    assign bc_after = r_bit_cnt - i_value_width;
    assign cond     = (r_burst < BURST_W'(MAX_BURST)) && (r_bit_cnt >= i_value_width)
                   && (r_run_rem != '0) && (r_dec_cnt < i_total_values);
    assign nxt      = (r_burst < BURST_W'(MAX_BURST - 1)) && (bc_after >= i_value_width)
                   && (r_run_rem != 32'd1) && ((r_dec_cnt + TOTAL_W'(1)) < i_total_values);
    assign do_emit  = (r_est == ES_UNPACK) && cond && slot_free;
    assign do_end   = cond ? (do_emit && !nxt) : (!r_eop_hold || slot_free);

    always_comb begin
        n_est       = r_est;
        n_phase     = r_phase;
        n_pfx_cnt   = r_pfx_cnt;
        n_hdr_acc   = r_hdr_acc;
        n_hdr_shift = r_hdr_shift;
        n_run_rem   = r_run_rem;
        n_val_acc   = r_val_acc;
        n_val_cnt   = r_val_cnt;
        n_bit_buf   = r_bit_buf;
        n_bit_cnt   = r_bit_cnt;
        n_dec_cnt   = r_dec_cnt;
        n_burst     = r_burst;
        n_eop_hold  = r_eop_hold;
        o_cmd_pop   = 1'b0;
        go_unpack   = 1'b0;
        emit        = 1'b0;
        res         = '0;

        case (r_est)
            ES_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    o_cmd_pop = 1'b1;
                    case (r_phase)
                        PH_PREFIX: begin
                            if (r_pfx_cnt == 2'd3) begin
                                n_pfx_cnt = 2'd0;
                                n_phase   = PH_HEADER;
                            end else begin
                                n_pfx_cnt = r_pfx_cnt + 2'd1;
                            end
                        end
                        PH_HEADER, PH_PACKED, PH_RLEVAL: begin
                            if (!wok) begin
                                n_phase = PH_FAIL;
                            end else if (r_dec_cnt >= i_total_values) begin
                                n_phase = PH_DONE;
                            end else begin
                                case (r_phase)
                                    PH_HEADER: begin
                                        n_hdr_acc = hdr_new;
                                        if (!i_cmd.cont || hs_sat == 3'd4) begin
                                            n_hdr_acc   = '0;
                                            n_hdr_shift = '0;
                                            if (hdr_new[0]) begin
                                                n_run_rem = {1'b0, hdr_new[31:1]};
                                                n_val_acc = '0;
                                                n_val_cnt = '0;
                                                n_phase   = PH_RLEVAL;
                                            end else begin
                                                n_run_rem = pk_run;
                                                n_bit_buf = '0;
                                                n_bit_cnt = '0;
                                                n_phase   = (pk_run != '0) ? PH_PACKED
                                                                           : PH_HEADER;
                                            end
                                        end else begin
                                            n_hdr_shift = hs_sat + 3'd1;
                                        end
                                    end
                                    PH_PACKED: begin
                                        // shift wraps at 32 when leftover bits pile up
                                        n_bit_buf  = r_bit_buf
                                                   | ({32'd0, i_cmd.data} << r_bit_cnt[4:0]);
                                        n_bit_cnt  = r_bit_cnt + 6'd8;
                                        n_eop_hold = i_cmd.eop;
                                        n_burst    = '0;
                                        n_est      = ES_UNPACK;
                                        go_unpack  = 1'b1;
                                    end
                                    default: begin
                                        n_val_acc = val_new;
                                        n_val_cnt = vbc_new;
                                        if (vbc_new >= nb) begin
                                            if (rle_cnt != '0) begin
                                                emit      = 1'b1;
                                                res.index = val_new & mask;
                                                res.rep   = rle_cnt;
                                                n_dec_cnt = r_dec_cnt + rle_cnt;
                                            end
                                            n_run_rem = '0;
                                            n_val_acc = '0;
                                            n_val_cnt = '0;
                                            n_phase   = PH_HEADER;
                                        end
                                    end
                                endcase
                                if (!go_unpack && n_dec_cnt >= i_total_values) begin
                                    n_phase = PH_DONE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    res.last = 1'b1;
                    if (!go_unpack && i_cmd.eop) begin
                        emit = 1'b1;
                        if (!wok || n_phase == PH_PREFIX || n_phase == PH_FAIL) begin
                            res.status = ST_ERROR;
                        end else begin
                            res.status = (n_dec_cnt >= i_total_values) ? ST_COMPLETE
                                                                        : ST_ERROR;
                        end
                        n_phase     = PH_PREFIX;
                        n_pfx_cnt   = '0;
                        n_hdr_acc   = '0;
                        n_hdr_shift = '0;
                        n_run_rem   = '0;
                        n_val_acc   = '0;
                        n_val_cnt   = '0;
                        n_bit_buf   = '0;
                        n_bit_cnt   = '0;
                        n_dec_cnt   = '0;
                    end
                end
            end
            ES_UNPACK: begin
                if (do_emit) begin
                    emit      = 1'b1;
                    res.index = r_bit_buf[31:0] & mask;
                    res.rep   = TOTAL_W'(1);
                    n_bit_buf = r_bit_buf >> i_value_width;
                    n_bit_cnt = bc_after;
                    n_run_rem = r_run_rem - 32'd1;
                    n_dec_cnt = r_dec_cnt + TOTAL_W'(1);
                    n_burst   = r_burst + BURST_W'(1);
                end
                if (do_end) begin
                    res.last = 1'b1;
                    n_est    = ES_IDLE;
                    if (n_run_rem == '0) begin
                        n_bit_buf = '0;
                        n_bit_cnt = '0;
                        n_phase   = PH_HEADER;
                    end
                    if (n_dec_cnt >= i_total_values) begin
                        n_phase = PH_DONE;
                    end
                    if (r_eop_hold) begin
                        emit       = 1'b1;
                        res.status = (n_dec_cnt >= i_total_values) ? ST_COMPLETE : ST_ERROR;
                        n_phase     = PH_PREFIX;
                        n_pfx_cnt   = '0;
                        n_hdr_acc   = '0;
                        n_hdr_shift = '0;
                        n_run_rem   = '0;
                        n_val_acc   = '0;
                        n_val_cnt   = '0;
                        n_bit_buf   = '0;
                        n_bit_cnt   = '0;
                        n_dec_cnt   = '0;
                    end
                end
            end
            default: begin
                n_est = ES_IDLE;
            end
        endcase

        n_out_valid = emit || (r_out_valid && !i_res_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est       <= ES_IDLE;
            r_phase     <= PH_PREFIX;
            r_pfx_cnt   <= '0;
            r_hdr_acc   <= '0;
            r_hdr_shift <= '0;
            r_run_rem   <= '0;
            r_val_acc   <= '0;
            r_val_cnt   <= '0;
            r_bit_buf   <= '0;
            r_bit_cnt   <= '0;
            r_dec_cnt   <= '0;
            r_burst     <= '0;
            r_eop_hold  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_est       <= n_est;
            r_phase     <= n_phase;
            r_pfx_cnt   <= n_pfx_cnt;
            r_hdr_acc   <= n_hdr_acc;
            r_hdr_shift <= n_hdr_shift;
            r_run_rem   <= n_run_rem;
            r_val_acc   <= n_val_acc;
            r_val_cnt   <= n_val_cnt;
            r_bit_buf   <= n_bit_buf;
            r_bit_cnt   <= n_bit_cnt;
            r_dec_cnt   <= n_dec_cnt;
            r_burst     <= n_burst;
            r_eop_hold  <= n_eop_hold;
            r_out_valid <= n_out_valid;
            if (emit) begin
                r_out <= res;
            end
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

endmodule
